>>> sv/assert_macros.svh
// Assertion macros shared by the prefetch policy RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPP_ASSERT(lbl, clk, rstn, prop, msg)
`define MPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/mpp_pkg.sv
// Types, constants and sequencer states of the Markov page prefetch policy.
// No dependencies; the scan unit, the policy unit and the bench import it.
package mpp_pkg;

  localparam int NUM_PAGES   = 20;
  localparam int NUM_PROCS   = 20;
  localparam int PAGE_SIZE   = 128;
  localparam int COUNT_WIDTH = 16;

  localparam int PROC_W = 5;
  localparam int PC_W   = 12;
  localparam int MASK_W = 20;

  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int PROC_IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CNT_DEPTH  = NUM_PAGES * NUM_PAGES;
  localparam int CNT_AW     = $clog2(CNT_DEPTH);
  localparam int COL_W      = $clog2(NUM_PAGES + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [NUM_PAGES-1:0] page_mask_t;

  typedef struct packed {
    logic [PROC_W-1:0] process_id;
    logic              is_active;
    logic [PC_W-1:0]   program_counter;
    logic [MASK_W-1:0] resident_pages;
  } in_item_t;

  typedef struct packed {
    logic [PROC_W-1:0] served_process;
    logic [MASK_W-1:0] pagein_mask;
    logic [MASK_W-1:0] pageout_mask;
  } out_item_t;

  typedef struct packed {
    logic nonzero;
    logic dominant;
  } scan_flags_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_PREV_CHK,
    ST_CNT_WR,
    ST_TOT_RD,
    ST_SCAN,
    ST_LOOK,
    ST_DONE
  } state_e;

endpackage

>>> sv/mpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Uses no package; sized by its parameters.
module mpp_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data when no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/mpp_scan_unit.sv
// Shared compare unit: tests one transition count against its row total.
// Depends on mpp_pkg.
module mpp_scan_unit
  import mpp_pkg::*;
(
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic [COUNT_WIDTH-1:0] total_i,
  output scan_flags_t            flags_o
);

  localparam int EW = COUNT_WIDTH + 3;

  logic [EW-1:0] count_x5;
  logic [EW-1:0] total_x4;

  // share above four fifths: 5*count > 4*total
  assign count_x5 = (EW'(count_i) << 2) + EW'(count_i);
  assign total_x4 = EW'(total_i) << 2;

  assign flags_o.nonzero  = (count_i != '0);
  assign flags_o.dominant = (count_x5 > total_x4);

endmodule

>>> sv/markov_page_prefetch_policy_unit.sv
// Markov page prefetch policy: one item per process tick, one result per valid item.
// Each accepted item walks the current page's count row plus at most one look-ahead
// row, one count RAM read a cycle. A new item is taken only once the last result is
// registered; dropped items do not leave idle.
// After reset a clearing pass zeroes the count and total RAMs; no item
// is accepted meanwhile. Depends on mpp_pkg, mpp_ram, mpp_scan_unit, assert_macros.svh.
`include "assert_macros.svh"

module markov_page_prefetch_policy_unit
  import mpp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e state_q, state_d;

  logic [CNT_AW-1:0] clr_q;
  logic [COL_W-1:0]  col_q;
  logic              look_vld_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [PROC_W-1:0] proc_q;
  logic [PAGE_W-1:0] page_q;
  logic [PAGE_W-1:0] prev_q;
  logic [PAGE_W-1:0] look_q;
  page_mask_t        res_q;
  page_mask_t        mark_q;

  logic [PAGE_W-1:0] last_page_q [NUM_PROCS];
  logic [NUM_PROCS-1:0] last_vld_q;

  // count RAM and total RAM ports
  logic                   cnt_we, cnt_re;
  logic [CNT_AW-1:0]      cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   tot_we, tot_re;
  logic [PAGE_W-1:0]      tot_waddr, tot_raddr;
  logic [COUNT_WIDTH-1:0] tot_wdata, tot_rdata;

  scan_flags_t flags;

  logic              in_acc;
  logic              in_good;
  logic [PC_W-1:0]   pc_page;
  logic [PROC_IDX_W-1:0] pidx;
  logic              need_upd;
  logic              pend;
  logic [PAGE_W-1:0] pcol;
  logic [PAGE_W-1:0] scan_row;
  logic              scan_end;
  logic              look_hit;
  logic              out_free;
  page_mask_t        pagein;
  page_mask_t        pageout;

  function automatic logic [CNT_AW-1:0] cnt_addr(input logic [PAGE_W-1:0] row,
                                                 input logic [PAGE_W-1:0] col);
    cnt_addr = CNT_AW'(row) * CNT_AW'(NUM_PAGES) + CNT_AW'(col);
  endfunction

  mpp_ram #(
    .DEPTH (CNT_DEPTH),
    .WIDTH (COUNT_WIDTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mpp_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (COUNT_WIDTH)
  ) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  mpp_scan_unit u_scan (
    .count_i (cnt_rdata),
    .total_i (tot_rdata),
    .flags_o (flags)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign pc_page     = PC_W'(in_item_i.program_counter / PAGE_SIZE);
  assign in_good     = in_item_i.is_active && (in_item_i.process_id < NUM_PROCS) &&
                       (pc_page < NUM_PAGES);
  assign pidx        = PROC_IDX_W'(proc_q);
  assign need_upd    = last_vld_q[pidx] && (last_page_q[pidx] != page_q);
  assign pend        = (col_q != '0);
  assign pcol        = PAGE_W'(col_q - 1'b1);
  assign scan_row    = (state_q == ST_LOOK) ? look_q : page_q;
  assign scan_end    = (col_q == COL_W'(NUM_PAGES));
  assign look_hit    = (state_q == ST_SCAN) && pend && flags.dominant;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pagein      = mark_q & ~res_q;
  assign pageout     = ~mark_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CNT_AW'(CNT_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && in_good) state_d = ST_START;
      end
      ST_START: begin
        state_d = need_upd ? ST_PREV_CHK : ST_TOT_RD;
      end
      ST_PREV_CHK: begin
        state_d = (tot_rdata != COUNT_MAX) ? ST_CNT_WR : ST_TOT_RD;
      end
      ST_CNT_WR: begin
        state_d = ST_TOT_RD;
      end
      ST_TOT_RD: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_d = (look_vld_q || look_hit) ? ST_LOOK : ST_DONE;
      end
      ST_LOOK: begin
        if (scan_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = cnt_addr(prev_q, page_q);
    cnt_wdata = cnt_rdata + 1'b1;
    cnt_re    = 1'b0;
    cnt_raddr = cnt_addr(scan_row, PAGE_W'(col_q));
    tot_we    = 1'b0;
    tot_waddr = prev_q;
    tot_wdata = tot_rdata + 1'b1;
    tot_re    = 1'b0;
    tot_raddr = page_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        tot_we    = (clr_q < CNT_AW'(NUM_PAGES));
        tot_waddr = PAGE_W'(clr_q);
        tot_wdata = '0;
      end
      ST_START: begin
        tot_re    = 1'b1;
        tot_raddr = last_page_q[pidx];
      end
      ST_PREV_CHK: begin
        // bump the row total unless the row is frozen
        tot_we    = (tot_rdata != COUNT_MAX);
        cnt_re    = 1'b1;
        cnt_raddr = cnt_addr(prev_q, page_q);
      end
      ST_CNT_WR: begin
        cnt_we = 1'b1;
      end
      ST_TOT_RD: begin
        tot_re = 1'b1;
      end
      ST_SCAN, ST_LOOK: begin
        cnt_re = !scan_end;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      look_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_vld_q  <= '0;
      for (int p = 0; p < NUM_PROCS; p++) last_page_q[p] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_IDLE) look_vld_q <= 1'b0;
      if (look_hit) look_vld_q <= 1'b1;
      if (state_q == ST_START) begin
        last_page_q[pidx] <= page_q;
        last_vld_q[pidx]  <= 1'b1;
      end
      if ((state_q == ST_SCAN || state_q == ST_LOOK) && !scan_end) begin
        col_q <= col_q + 1'b1;
      end else begin
        col_q <= '0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      proc_q <= in_item_i.process_id;
      page_q <= PAGE_W'(pc_page);
      res_q  <= NUM_PAGES'(in_item_i.resident_pages);
      mark_q <= page_mask_t'(1) << PAGE_W'(pc_page);
    end
    if (state_q == ST_START) prev_q <= last_page_q[pidx];
    if ((state_q == ST_SCAN || state_q == ST_LOOK) && pend && flags.nonzero) begin
      mark_q[pcol] <= 1'b1;
    end
    if (look_hit) look_q <= pcol;
    if (state_q == ST_DONE && out_free) begin
      out_q.served_process <= proc_q;
      out_q.pagein_mask    <= MASK_W'(pagein);
      out_q.pageout_mask   <= MASK_W'(pageout);
    end
  end

  `MPP_ASSERT(a_page_marked, clk_i, rst_ni, (state_q == ST_DONE) |-> mark_q[page_q], "current page not marked")
  `MPP_ASSERT(a_cnt_wr_order, clk_i, rst_ni, (state_q == ST_CNT_WR) |-> ($past(state_q) == ST_PREV_CHK), "count write out of order")
  `MPP_ASSERT(a_one_dominant, clk_i, rst_ni, (state_q == ST_SCAN && look_vld_q) |-> !look_hit, "two dominant successors")
  `MPP_ASSERT(a_done_holds, clk_i, rst_ni, (state_q == ST_DONE && out_valid_q && out_stall_i) |=> (state_q == ST_DONE), "result dropped while output stalled")

endmodule

>>> test/markov_page_prefetch_policy_unit_tb.sv
// Self-checking bench for markov_page_prefetch_policy_unit: directed ticks, then random
// process walks with bursty input and a stalling receiver, checked against a transition-count
// predictor. Depends on mpp_pkg and the unit RTL.
`timescale 1ns / 1ps

module markov_page_prefetch_policy_unit_tb;
  import mpp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1620;
  localparam int unsigned HOLD_CYCLES  = 600;

  // Transition-count predictor plus the queue of masks still owed by the unit.
  class page_predict_board;
    logic [COUNT_WIDTH-1:0] trans_cnt [NUM_PAGES][NUM_PAGES];
    logic [COUNT_WIDTH-1:0] row_sum [NUM_PAGES];
    int unsigned prev_page [NUM_PROCS];
    bit prev_known [NUM_PROCS];
    out_item_t due_q [$];
    int unsigned errors;

    function new();
      for (int r = 0; r < NUM_PAGES; r++) begin
        row_sum[r] = '0;
        for (int c = 0; c < NUM_PAGES; c++) trans_cnt[r][c] = '0;
      end
      for (int p = 0; p < NUM_PROCS; p++) begin
        prev_page[p] = 0;
        prev_known[p] = 1'b0;
      end
      errors = 0;
    endfunction

    function page_mask_t succ_mask(int unsigned row);
      page_mask_t m;
      m = '0;
      for (int c = 0; c < NUM_PAGES; c++) m[c] = (trans_cnt[row][c] != '0);
      return m;
    endfunction

    // Returns 1 when the item owes a result.
    function bit note_input(in_item_t it);
      int unsigned pid, pg, prv;
      longint unsigned cnt, tot;
      page_mask_t marked, res;
      out_item_t exp_item;
      if (!it.is_active) return 1'b0;
      pid = 32'(it.process_id);
      if (pid >= NUM_PROCS) return 1'b0;
      pg = it.program_counter / PAGE_SIZE;
      if (pg >= NUM_PAGES) return 1'b0;
      if (prev_known[pid] && prev_page[pid] != pg) begin
        prv = prev_page[pid];
        // frozen row once its total saturates
        if (row_sum[prv] != COUNT_MAX) begin
          row_sum[prv] = row_sum[prv] + 1'b1;
          trans_cnt[prv][pg] = trans_cnt[prv][pg] + 1'b1;
        end
      end
      prev_page[pid] = pg;
      prev_known[pid] = 1'b1;
      marked = '0;
      marked[pg] = 1'b1;
      if (row_sum[pg] != '0) begin
        marked |= succ_mask(pg);
        tot = 64'(row_sum[pg]);
        for (int c = 0; c < NUM_PAGES; c++) begin
          cnt = 64'(trans_cnt[pg][c]);
          if (5 * cnt > 4 * tot && row_sum[c] != '0) marked |= succ_mask(c);
        end
      end
      res = it.resident_pages[NUM_PAGES-1:0];
      exp_item.served_process = it.process_id;
      exp_item.pagein_mask = MASK_W'(marked & ~res);
      exp_item.pageout_mask = MASK_W'(~marked);
      due_q.push_back(exp_item);
      return 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (due_q.size() == 0) begin
        $error("unexpected item: served_process %0d", got.served_process);
        errors++;
        return;
      end
      exp_item = due_q.pop_front();
      if (got.served_process !== exp_item.served_process) begin
        $error("served_process: expected %0d, actual %0d",
               exp_item.served_process, got.served_process);
        errors++;
      end
      if (got.pagein_mask !== exp_item.pagein_mask) begin
        $error("pagein_mask: expected %05h, actual %05h",
               exp_item.pagein_mask, got.pagein_mask);
        errors++;
      end
      if (got.pageout_mask !== exp_item.pageout_mask) begin
        $error("pageout_mask: expected %05h, actual %05h",
               exp_item.pageout_mask, got.pageout_mask);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  bit hold_req = 1'b0;

  page_predict_board board = new();

  markov_page_prefetch_policy_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_item_o);
  end

  // Receiver: stall in modes of random length, plus one long hold-off on request.
  initial begin
    int unsigned mode_left, stall_pct, hold_cnt;
    mode_left = 0;
    stall_pct = 0;
    hold_cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 300);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 70;
            default: stall_pct = 95;
          endcase
        end
        mode_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic in_item_t tick(int unsigned pid, bit act, int unsigned pc,
                                    logic [MASK_W-1:0] res);
    in_item_t it;
    it.process_id = PROC_W'(pid);
    it.is_active = act;
    it.program_counter = PC_W'(pc);
    it.resident_pages = res;
    return it;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input in_item_t it, output bit made);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    made = board.note_input(it);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n == 0) return;
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [MASK_W-1:0] pick_resident();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return MASK_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed walks that follow a preferred successor, with some noise.
  function automatic in_item_t random_tick(int unsigned follow_pct,
                                           int unsigned succ_tbl [NUM_PAGES]);
    int unsigned pid, pg, r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return tick($urandom_range(0, 31), 1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                  MASK_W'($urandom));
    if (r < 12)
      return tick($urandom_range(0, 31), 1'b0, $urandom_range(0, 4095), MASK_W'($urandom));
    pid = $urandom_range(0, NUM_PROCS - 1);
    pg = board.prev_page[pid];
    r = $urandom_range(0, 99);
    if (r < follow_pct) pg = succ_tbl[pg];
    else if (r < follow_pct + (100 - follow_pct) / 3) pg = pg;
    else pg = $urandom_range(0, NUM_PAGES - 1);
    return tick(pid, 1'b1, pg * PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1), pick_resident());
  endfunction

  initial begin
    in_item_t directed_q [$];
    int unsigned succ_tbl [NUM_PAGES];
    int unsigned produced, sent, burst, follow_pct;
    bit made, hold_sent, paused;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // skips: inactive, process id out of range, page out of range
    directed_q.push_back(tick(0, 1'b0, 0, '0));
    directed_q.push_back(tick(31, 1'b1, 100, '1));
    directed_q.push_back(tick(NUM_PROCS, 1'b1, 200, '0));
    directed_q.push_back(tick(1, 1'b1, 4095, '1));
    directed_q.push_back(tick(1, 1'b1, NUM_PAGES * PAGE_SIZE, '0));
    // first page, same page, last page, wrap back
    directed_q.push_back(tick(0, 1'b1, 0, '0));
    directed_q.push_back(tick(0, 1'b1, PAGE_SIZE - 1, '1));
    directed_q.push_back(tick(0, 1'b1, NUM_PAGES * PAGE_SIZE - 1, '1));
    directed_q.push_back(tick(0, 1'b1, 0, 20'h55555));
    directed_q.push_back(tick(NUM_PROCS - 1, 1'b1, PAGE_SIZE, 20'hAAAAA));
    directed_q.push_back(tick(NUM_PROCS - 1, 1'b1, NUM_PAGES * PAGE_SIZE - 1, '0));
    directed_q.push_back(tick(NUM_PROCS - 1, 1'b1, PAGE_SIZE, '1));
    // one dominant successor drives the look-ahead row
    for (int n = 0; n < 4; n++) begin
      directed_q.push_back(tick(5, 1'b1, 3 * PAGE_SIZE, 20'h00008));
      directed_q.push_back(tick(5, 1'b1, 4 * PAGE_SIZE + 7, '0));
    end
    directed_q.push_back(tick(6, 1'b1, 3 * PAGE_SIZE + 1, '0));
    directed_q.push_back(tick(6, 1'b1, 9 * PAGE_SIZE, '1));
    directed_q.push_back(tick(7, 1'b1, 3 * PAGE_SIZE, '0));
    foreach (directed_q[i]) send_item(directed_q[i], made);
    wait_drained();

    foreach (succ_tbl[i]) succ_tbl[i] = $urandom_range(0, NUM_PAGES - 1);
    produced = 0;
    sent = 0;
    hold_sent = 1'b0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: follow_pct = 50;
        1: follow_pct = 85;
        default: follow_pct = 97;
      endcase
      if ($urandom_range(0, 19) == 0)
        succ_tbl[$urandom_range(0, NUM_PAGES - 1)] = $urandom_range(0, NUM_PAGES - 1);
      repeat (burst) begin
        send_item(random_tick(follow_pct, succ_tbl), made);
        sent++;
        if (made) produced++;
        if (!hold_sent && produced >= 300) begin
          hold_req = 1'b1;
          hold_sent = 1'b1;
        end
      end
      if (!paused && produced >= 800) begin
        wait_drained();
        paused = 1'b1;
      end
      idle_for(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/mpp_pkg.sv
sv/mpp_ram.sv
sv/mpp_scan_unit.sv
sv/markov_page_prefetch_policy_unit.sv
test/markov_page_prefetch_policy_unit_tb.sv
